// ----- rtl/sswu_pkg.sv -----
// ----------------------------------------------------------------------------
// sswu_pkg
// Shared constants, types and the breakpoint table of the sliding window
// symbolic word unit.
// ----------------------------------------------------------------------------
package sswu_pkg;

    localparam int MAX_WINDOW  = 256;
    localparam int MAX_WORD    = 16;
    localparam int SAMPLE_BITS = 16;
    localparam int MIN_ALPHA   = 2;
    localparam int MAX_ALPHA   = 20;
    localparam int FRAC_BITS   = 8;

    localparam int ADDR_W  = $clog2(MAX_WINDOW);
    localparam int N_W     = ADDR_W + 1;
    localparam int WD_W    = $clog2(MAX_WORD) + 1;
    localparam int POS_IDX_W = $clog2(MAX_WORD);
    localparam int ALPHA_W = 5;
    localparam int SYM_W   = 5;
    localparam int THR_W   = 16;
    localparam int MODE_W  = 2;
    localparam int CNT_W   = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int SUM_W  = SAMPLE_BITS + ADDR_W + 1;
    localparam int SQ_W   = 2 * SAMPLE_BITS + ADDR_W - 1;
    localparam int NQ_W   = N_W + SQ_W;
    localparam int SS_W   = 2 * SUM_W;
    localparam int D_W    = NQ_W + (NQ_W % 2);
    localparam int M_W    = 2 * N_W;
    localparam int SD_W   = D_W / 2;
    localparam int BASE_W = SD_W + N_W;
    localparam int P_W    = SUM_W;
    localparam int LHS_W  = P_W + 8;
    localparam int CMP_W  = BASE_W + 11;
    localparam int POS_W  = $clog2(MAX_WINDOW * MAX_WORD) + 2;
    localparam int LEN_W  = WD_W;
    localparam int CUT_W  = 9;
    localparam int ROWS   = MAX_ALPHA - 1;

    localparam logic [N_W-1:0]     RST_WINDOW_LENGTH  = N_W'(128);
    localparam logic [WD_W-1:0]    RST_WORD_LENGTH    = WD_W'(4);
    localparam logic [ALPHA_W-1:0] RST_ALPHABET_SIZE  = ALPHA_W'(4);
    localparam logic [THR_W-1:0]   RST_FLAT_THRESHOLD = THR_W'(3);
    localparam logic [MODE_W-1:0]  RST_REDUCTION_MODE = MODE_W'(1);

    localparam logic [MODE_W-1:0] RED_NONE  = MODE_W'(0);
    localparam logic [MODE_W-1:0] RED_EXACT = MODE_W'(1);
    localparam logic [MODE_W-1:0] RED_NEAR  = MODE_W'(2);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_LENGTH,
        REG_WORD_LENGTH,
        REG_ALPHABET_SIZE,
        REG_FLAT_THRESHOLD,
        REG_REDUCTION_MODE
    } t_reg_idx;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_SUM,
        OP_PROD,
        OP_DIFF,
        OP_DIV,
        OP_SQRT,
        OP_BASE,
        OP_WALK,
        OP_CMP,
        OP_RED,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic accept;
        logic emit_next;
    } t_cmd;

    typedef struct packed {
        logic not_full;
        logic sum_done;
        logic div_done;
        logic sqrt_done;
        logic walk_done;
        logic cmp_done;
        logic drop;
        logic emit_last;
    } t_status;

    typedef logic signed [CUT_W-1:0] t_cut;

    localparam t_cut CUT_TAB [0:ROWS-1][0:ROWS-1] = '{
        '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{-43, 43, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{-67, 0, 67, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{-84, -25, 25, 84, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{-97, -43, 0, 43, 97, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{-107, -57, -18, 18, 57, 107, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{-115, -67, -32, 0, 32, 67, 115, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{-122, -76, -43, -14, 14, 43, 76, 122, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{-128, -84, -52, -25, 0, 25, 52, 84, 128, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{-134, -91, -60, -35, -11, 11, 35, 60, 91, 134, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{-138, -97, -67, -43, -21, 0, 21, 43, 67, 97, 138, 0, 0, 0, 0, 0, 0, 0, 0},
        '{-143, -102, -74, -50, -29, -10, 10, 29, 50, 74, 102, 143,
          0, 0, 0, 0, 0, 0, 0},
        '{-147, -107, -79, -57, -37, -18, 0, 18, 37, 57, 79, 107, 147,
          0, 0, 0, 0, 0, 0},
        '{-150, -111, -84, -62, -43, -25, -8, 8, 25, 43, 62, 84, 111, 150,
          0, 0, 0, 0, 0},
        '{-153, -115, -89, -67, -49, -32, -16, 0, 16, 32, 49, 67, 89, 115, 153,
          0, 0, 0, 0},
        '{-156, -119, -93, -72, -54, -38, -22, -7, 7, 22, 38, 54, 72, 93, 119, 156,
          0, 0, 0},
        '{-159, -122, -97, -76, -59, -43, -28, -14, 0, 14, 28, 43, 59, 76, 97, 122,
          159, 0, 0},
        '{-162, -125, -100, -80, -63, -48, -34, -20, -7, 7, 20, 34, 48, 63, 80, 100,
          125, 162, 0},
        '{-164, -128, -104, -84, -67, -52, -39, -25, -13, 0, 13, 25, 39, 52, 67, 84,
          104, 128, 164}
    };

endpackage

// ----- rtl/sswu_ctrl.sv -----
// ----------------------------------------------------------------------------
// sswu_ctrl
// Sequencer that steps the datapath through storing and, for a full window,
// statistics, segment walk, quantization, repeat check and symbol output.
// ----------------------------------------------------------------------------
module sswu_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_stall,
    input  sswu_pkg::t_status i_status,
    output sswu_pkg::t_cmd    o_cmd,
    output logic              o_valid,
    output logic              o_stall
);
    import sswu_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SUM,
        S_PROD,
        S_DIFF,
        S_DIV,
        S_SQRT,
        S_BASE,
        S_WALK,
        S_CMP,
        S_RED,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_valid) n_state = S_CHECK;
            S_CHECK: n_state = i_status.not_full ? S_IDLE : S_SUM;
            S_SUM:   if (i_status.sum_done) n_state = S_PROD;
            S_PROD:  n_state = S_DIFF;
            S_DIFF:  n_state = S_DIV;
            S_DIV:   if (i_status.div_done) n_state = S_SQRT;
            S_SQRT:  if (i_status.sqrt_done) n_state = S_BASE;
            S_BASE:  n_state = S_WALK;
            S_WALK:  if (i_status.walk_done) n_state = S_CMP;
            S_CMP:   if (i_status.cmp_done) n_state = S_RED;
            S_RED:   n_state = i_status.drop ? S_IDLE : S_EMIT;
            S_EMIT:  if (!i_stall && i_status.emit_last) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        unique case (r_state)
            S_SUM:   o_cmd.op = OP_SUM;
            S_PROD:  o_cmd.op = OP_PROD;
            S_DIFF:  o_cmd.op = OP_DIFF;
            S_DIV:   o_cmd.op = OP_DIV;
            S_SQRT:  o_cmd.op = OP_SQRT;
            S_BASE:  o_cmd.op = OP_BASE;
            S_WALK:  o_cmd.op = OP_WALK;
            S_CMP:   o_cmd.op = OP_CMP;
            S_RED:   o_cmd.op = OP_RED;
            S_EMIT:  o_cmd.op = OP_EMIT;
            default: o_cmd.op = OP_NONE;
        endcase
        o_cmd.accept    = (r_state == S_IDLE) && i_valid;
        o_cmd.emit_next = (r_state == S_EMIT) && !i_stall;
    end

    assign o_valid = (r_state == S_EMIT);
    assign o_stall = (r_state != S_IDLE);

endmodule

// ----- rtl/sswu_datapath.sv -----
// ----------------------------------------------------------------------------
// sswu_datapath
// Sample ring, configuration registers, window statistics with serial
// divider and square root, segment walker, breakpoint compare and word store.
// ----------------------------------------------------------------------------
module sswu_datapath (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  sswu_pkg::t_cmd                            i_cmd,
    input  logic signed [sswu_pkg::SAMPLE_BITS-1:0]   i_sample,
    input  logic                                      i_series_start,
    input  logic                                      i_cfg_write,
    input  logic [sswu_pkg::CFG_IDX_W-1:0]            i_cfg_index,
    input  logic [sswu_pkg::CFG_DATA_W-1:0]           i_cfg_data,
    output sswu_pkg::t_status                         o_status,
    output logic [sswu_pkg::CNT_W-1:0]                o_window_start,
    output logic [sswu_pkg::POS_IDX_W-1:0]            o_symbol_position,
    output logic [sswu_pkg::SYM_W-1:0]                o_symbol,
    output logic                                      o_last
);
    import sswu_pkg::*;

    localparam logic signed [7:0] PERCENT = 8'sd100;

    logic [N_W-1:0]     r_window_length;
    logic [WD_W-1:0]    r_word_length;
    logic [ALPHA_W-1:0] r_alphabet_size;
    logic [THR_W-1:0]   r_flat_threshold;
    logic [MODE_W-1:0]  r_reduction_mode;

    logic [N_W-1:0]     n;
    logic [WD_W-1:0]    w;
    logic [ALPHA_W-1:0] a;

    logic signed [SAMPLE_BITS-1:0] r_mem [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] r_rd_data;
    logic [ADDR_W-1:0]             rd_addr;
    logic                          r_rd_vld;

    logic [ADDR_W-1:0] r_wp;
    logic [N_W-1:0]    r_fill;
    logic [CNT_W-1:0]  r_cnt;
    logic [N_W-1:0]    fill_base;
    logic [CNT_W-1:0]  cnt_base;

    logic [N_W-1:0]           r_scnt;
    logic signed [SUM_W-1:0]  r_s;
    logic [SQ_W-1:0]          r_q;
    logic signed [2*SAMPLE_BITS-1:0] sq_c;
    logic [NQ_W-1:0]          r_nq;
    logic [NQ_W-1:0]          nq_c;
    logic signed [SS_W-1:0]   ss_c;
    logic [SS_W-1:0]          r_ss;
    logic [SS_W-1:0]          nq_ext;
    logic [D_W-1:0]           d_c;
    logic [M_W-1:0]           r_m;
    logic [M_W-1:0]           m_c;

    logic [D_W-1:0]            r_dq;
    logic [M_W-1:0]            r_drem;
    logic [$clog2(D_W+1)-1:0]  r_dcnt;
    logic [M_W:0]              drs;
    logic                      dge;

    logic [SD_W+1:0]           r_sqrem;
    logic [SD_W-1:0]           r_root;
    logic [$clog2(SD_W+1)-1:0] r_sqcnt;
    logic [SD_W+3:0]           srs;
    logic [SD_W+3:0]           strial;

    logic              r_flat;
    logic              flat_c;
    logic [BASE_W-1:0] r_base;
    logic [BASE_W-1:0] sdn_c;
    logic [BASE_W-1:0] base_c;

    logic [POS_W-1:0]     r_i;
    logic [POS_W-1:0]     r_kend;
    logic [POS_W-1:0]     r_segend;
    logic [N_W-1:0]       r_k;
    logic [WD_W-1:0]      r_j;
    logic [POS_W-1:0]     stop_c;
    logic [LEN_W-1:0]     len_c;
    logic [LEN_W-1:0]     r_wlen;
    logic                 r_wlast;
    logic [POS_IDX_W-1:0] r_wseg;
    logic signed [SAMPLE_BITS+LEN_W:0] wprod_c;
    logic signed [P_W-1:0] r_pacc;
    logic signed [P_W-1:0] acc_c;
    logic signed [P_W-1:0] r_p [MAX_WORD];

    logic [WD_W-1:0]        r_cj;
    logic [SYM_W-1:0]       r_ck;
    logic                   r_lhs_ok;
    logic signed [LHS_W-1:0] r_lhs;
    logic signed [P_W:0]    pdiff_c;
    logic signed [LHS_W-1:0] lhs_c;
    logic [ALPHA_W-1:0]     row_c;
    logic signed [CMP_W-1:0] bp_c;
    logic                   ge_c;

    logic [SYM_W-1:0]  r_word [MAX_WORD];
    logic [SYM_W-1:0]  r_prev [MAX_WORD];
    logic [WD_W-1:0]   r_prev_len;
    logic              r_prev_valid;
    logic [MAX_WORD-1:0] lane_ok;
    logic              drop_c;

    logic [POS_IDX_W-1:0] r_eidx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length  <= RST_WINDOW_LENGTH;
            r_word_length    <= RST_WORD_LENGTH;
            r_alphabet_size  <= RST_ALPHABET_SIZE;
            r_flat_threshold <= RST_FLAT_THRESHOLD;
            r_reduction_mode <= RST_REDUCTION_MODE;
        end else if (i_cfg_write) begin
            unique case (i_cfg_index)
                REG_WINDOW_LENGTH:  r_window_length  <= i_cfg_data[N_W-1:0];
                REG_WORD_LENGTH:    r_word_length    <= i_cfg_data[WD_W-1:0];
                REG_ALPHABET_SIZE:  r_alphabet_size  <= i_cfg_data[ALPHA_W-1:0];
                REG_FLAT_THRESHOLD: r_flat_threshold <= i_cfg_data[THR_W-1:0];
                REG_REDUCTION_MODE: r_reduction_mode <= i_cfg_data[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_window_length < N_W'(2)) begin
            n = N_W'(2);
        end else if (r_window_length > N_W'(MAX_WINDOW)) begin
            n = N_W'(MAX_WINDOW);
        end else begin
            n = r_window_length;
        end
        if (r_word_length == '0) begin
            w = WD_W'(1);
        end else if (r_word_length > WD_W'(MAX_WORD)) begin
            w = WD_W'(MAX_WORD);
        end else begin
            w = r_word_length;
        end
        if (r_alphabet_size < ALPHA_W'(MIN_ALPHA)) begin
            a = ALPHA_W'(MIN_ALPHA);
        end else if (r_alphabet_size > ALPHA_W'(MAX_ALPHA)) begin
            a = ALPHA_W'(MAX_ALPHA);
        end else begin
            a = r_alphabet_size;
        end
    end

    always_comb begin
        if (i_cmd.op == OP_WALK) begin
            rd_addr = r_wp - n[ADDR_W-1:0] + r_k[ADDR_W-1:0];
        end else begin
            rd_addr = r_wp - n[ADDR_W-1:0] + r_scnt[ADDR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mem[r_wp] <= i_sample;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    assign fill_base = i_series_start ? '0 : r_fill;
    assign cnt_base  = i_series_start ? '0 : r_cnt;

    assign sq_c   = r_rd_data * r_rd_data;
    assign nq_c   = n * r_q;
    assign ss_c   = r_s * r_s;
    assign m_c    = M_W'(n) * M_W'(n - 1'b1);
    assign nq_ext = SS_W'(r_nq);
    assign d_c    = (nq_ext >= r_ss) ? D_W'(nq_ext - r_ss) : '0;

    assign drs = {r_drem, r_dq[D_W-1]};
    assign dge = (drs >= {1'b0, r_m});

    assign srs    = {r_sqrem, r_dq[D_W-1 -: 2]};
    assign strial = {2'b00, r_root, 2'b01};

    assign sdn_c  = r_root * n;
    assign flat_c = (r_root == '0) || (r_root < SD_W'(r_flat_threshold));
    assign base_c = flat_c ? (BASE_W'(n) << FRAC_BITS) : sdn_c;

    assign stop_c  = (r_kend < r_segend) ? r_kend : r_segend;
    assign len_c   = LEN_W'(stop_c - r_i);
    assign wprod_c = r_rd_data * $signed({1'b0, r_wlen});
    assign acc_c   = r_pacc + P_W'(wprod_c);

    assign pdiff_c = r_flat ? (P_W+1)'(r_p[r_cj[POS_IDX_W-1:0]])
                            : (P_W+1)'(r_p[r_cj[POS_IDX_W-1:0]]) - (P_W+1)'(r_s);
    assign lhs_c   = LHS_W'(pdiff_c) * LHS_W'(PERCENT);
    assign row_c   = ALPHA_W'(a - ALPHA_W'(MIN_ALPHA));
    assign bp_c    = CMP_W'(CUT_TAB[row_c][r_ck]) * CMP_W'($signed({1'b0, r_base}));
    assign ge_c    = (r_ck < SYM_W'(a - 1'b1)) && (CMP_W'(r_lhs) >= bp_c);

    always_comb begin
        for (int jj = 0; jj < MAX_WORD; jj++) begin
            if (WD_W'(jj) >= w) begin
                lane_ok[jj] = 1'b1;
            end else if (r_reduction_mode == RED_EXACT) begin
                lane_ok[jj] = (r_word[jj] == r_prev[jj]);
            end else begin
                lane_ok[jj] = (r_word[jj] == r_prev[jj])
                           || ({1'b0, r_word[jj]} == {1'b0, r_prev[jj]} + 1'b1)
                           || ({1'b0, r_prev[jj]} == {1'b0, r_word[jj]} + 1'b1);
            end
        end
        drop_c = r_prev_valid && (r_prev_len == w)
              && ((r_reduction_mode == RED_EXACT) || (r_reduction_mode == RED_NEAR))
              && (&lane_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp         <= '0;
            r_fill       <= '0;
            r_cnt        <= '0;
            r_prev_valid <= 1'b0;
            r_prev_len   <= '0;
            r_rd_vld     <= 1'b0;
            r_scnt       <= '0;
            r_dcnt       <= '0;
            r_sqcnt      <= '0;
            r_j          <= '0;
            r_cj         <= '0;
            r_ck         <= '0;
            r_lhs_ok     <= 1'b0;
            r_eidx       <= '0;
            for (int jj = 0; jj < MAX_WORD; jj++) begin
                r_prev[jj] <= '0;
            end
        end else begin
            if (i_cmd.accept) begin
                r_wp     <= r_wp + 1'b1;
                r_fill   <= (fill_base < N_W'(MAX_WINDOW)) ? fill_base + 1'b1 : fill_base;
                r_cnt    <= (cnt_base != '1) ? cnt_base + 1'b1 : cnt_base;
                if (i_series_start) begin
                    r_prev_valid <= 1'b0;
                end
                r_scnt   <= '0;
                r_s      <= '0;
                r_q      <= '0;
                r_rd_vld <= 1'b0;
            end
            unique case (i_cmd.op)
                OP_SUM: begin
                    if (r_scnt < n) begin
                        r_scnt   <= r_scnt + 1'b1;
                        r_rd_vld <= 1'b1;
                    end else begin
                        r_rd_vld <= 1'b0;
                    end
                    if (r_rd_vld) begin
                        r_s <= r_s + SUM_W'(r_rd_data);
                        r_q <= r_q + SQ_W'($unsigned(sq_c));
                    end
                end
                OP_PROD: begin
                    r_nq <= nq_c;
                    r_ss <= $unsigned(ss_c);
                    r_m  <= m_c;
                end
                OP_DIFF: begin
                    r_dq    <= d_c;
                    r_drem  <= '0;
                    r_dcnt  <= '0;
                    r_sqrem <= '0;
                    r_root  <= '0;
                    r_sqcnt <= '0;
                end
                OP_DIV: begin
                    if (r_dcnt != ($clog2(D_W+1))'(D_W)) begin
                        r_drem <= dge ? M_W'(drs - {1'b0, r_m}) : M_W'(drs);
                        r_dq   <= {r_dq[D_W-2:0], dge};
                        r_dcnt <= r_dcnt + 1'b1;
                    end
                end
                OP_SQRT: begin
                    if (r_sqcnt != ($clog2(SD_W+1))'(SD_W)) begin
                        if (srs >= strial) begin
                            r_sqrem <= (SD_W+2)'(srs - strial);
                            r_root  <= {r_root[SD_W-2:0], 1'b1};
                        end else begin
                            r_sqrem <= (SD_W+2)'(srs);
                            r_root  <= {r_root[SD_W-2:0], 1'b0};
                        end
                        r_dq    <= {r_dq[D_W-3:0], 2'b00};
                        r_sqcnt <= r_sqcnt + 1'b1;
                    end
                end
                OP_BASE: begin
                    r_flat   <= flat_c;
                    r_base   <= base_c;
                    r_i      <= '0;
                    r_j      <= '0;
                    r_k      <= '0;
                    r_kend   <= POS_W'(w);
                    r_segend <= POS_W'(n);
                    r_pacc   <= '0;
                    r_rd_vld <= 1'b0;
                    r_cj     <= '0;
                    r_ck     <= '0;
                    r_lhs_ok <= 1'b0;
                end
                OP_WALK: begin
                    if (r_j < w) begin
                        r_wlen   <= len_c;
                        r_wlast  <= (stop_c == r_segend);
                        r_wseg   <= r_j[POS_IDX_W-1:0];
                        r_rd_vld <= 1'b1;
                        r_i      <= stop_c;
                        if (stop_c == r_kend) begin
                            r_k    <= r_k + 1'b1;
                            r_kend <= r_kend + POS_W'(w);
                        end
                        if (stop_c == r_segend) begin
                            r_j      <= r_j + 1'b1;
                            r_segend <= r_segend + POS_W'(n);
                        end
                    end else begin
                        r_rd_vld <= 1'b0;
                    end
                    if (r_rd_vld) begin
                        if (r_wlast) begin
                            r_p[r_wseg] <= acc_c;
                            r_pacc      <= '0;
                        end else begin
                            r_pacc <= acc_c;
                        end
                    end
                end
                OP_CMP: begin
                    if (r_cj < w) begin
                        if (!r_lhs_ok) begin
                            r_lhs    <= lhs_c;
                            r_lhs_ok <= 1'b1;
                        end else if (ge_c) begin
                            r_ck <= r_ck + 1'b1;
                        end else begin
                            r_word[r_cj[POS_IDX_W-1:0]] <= r_ck;
                            r_cj     <= r_cj + 1'b1;
                            r_ck     <= '0;
                            r_lhs_ok <= 1'b0;
                        end
                    end
                end
                OP_RED: begin
                    if (!drop_c) begin
                        for (int jj = 0; jj < MAX_WORD; jj++) begin
                            r_prev[jj] <= r_word[jj];
                        end
                        r_prev_len   <= w;
                        r_prev_valid <= 1'b1;
                        r_eidx       <= '0;
                    end
                end
                default: ;
            endcase
            if (i_cmd.emit_next) begin
                r_eidx <= r_eidx + 1'b1;
            end
        end
    end

    always_comb begin
        o_status.not_full  = (r_fill < n);
        o_status.sum_done  = (r_scnt == n) && !r_rd_vld;
        o_status.div_done  = (r_dcnt == ($clog2(D_W+1))'(D_W));
        o_status.sqrt_done = (r_sqcnt == ($clog2(SD_W+1))'(SD_W));
        o_status.walk_done = (r_j == w) && !r_rd_vld;
        o_status.cmp_done  = (r_cj == w);
        o_status.drop      = drop_c;
        o_status.emit_last = (r_eidx == POS_IDX_W'(w - 1'b1));
    end

    assign o_window_start    = (r_cnt == '1) ? '1 : r_cnt - CNT_W'(n);
    assign o_symbol_position = r_eidx;
    assign o_symbol          = r_word[r_eidx];
    assign o_last            = (r_eidx == POS_IDX_W'(w - 1'b1));

endmodule

// ----- rtl/sax_sliding_window_words_unit.sv -----
// ----------------------------------------------------------------------------
// sax_sliding_window_words_unit
// Sliding window symbolic word generator: one Q8.8 sample in, one word of
// quantized segment means out, one symbol per output request.
// ----------------------------------------------------------------------------
// The unit takes one sample request at a time and holds o_stall high until
// that sample is fully handled. With a full window of n samples and w
// symbols per word, the window is read through the single read port of the
// sample ring for the sums and again for the segment walk, the deviation
// comes from a serial divider producing one quotient bit per cycle and a
// serial square root producing one root bit per cycle, and each symbol is
// found by stepping through the breakpoint row one entry per cycle. A
// dropped repeat word gives no output requests.
module sax_sliding_window_words_unit (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    output logic                                     o_stall,
    input  logic signed [sswu_pkg::SAMPLE_BITS-1:0]  i_sample,
    input  logic                                     i_series_start,
    output logic                                     o_valid,
    input  logic                                     i_stall,
    output logic [sswu_pkg::CNT_W-1:0]               o_window_start,
    output logic [sswu_pkg::POS_IDX_W-1:0]           o_symbol_position,
    output logic [sswu_pkg::SYM_W-1:0]               o_symbol,
    output logic                                     o_last,
    input  logic                                     i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  logic [sswu_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [sswu_pkg::CFG_DATA_W-1:0]          i_cfg_data
);
    import sswu_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    sswu_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_stall  (i_stall),
        .i_status (status),
        .o_cmd    (cmd),
        .o_valid  (o_valid),
        .o_stall  (o_stall)
    );

    sswu_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_sample          (i_sample),
        .i_series_start    (i_series_start),
        .i_cfg_write       (i_cfg_valid && o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_status          (status),
        .o_window_start    (o_window_start),
        .o_symbol_position (o_symbol_position),
        .o_symbol          (o_symbol),
        .o_last            (o_last)
    );

    a_no_accept_while_emit: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) o_valid |-> o_stall
    ) else $error("Input accepted while a word is being sent.");

    a_position_steps: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last) |=>
        (o_valid && (o_symbol_position == $past(o_symbol_position) + 1'b1))
    ) else $error("Symbol position did not advance within a word.");

    a_start_held_in_word: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last) |=> $stable(o_window_start)
    ) else $error("Window start changed inside a word.");

    a_symbol_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_symbol < SYM_W'(MAX_ALPHA))
    ) else $error("Symbol beyond the largest alphabet.");

endmodule

// ----- tb/tb_sax_sliding_window_words_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sax_sliding_window_words_unit
// Self-checking bench for the sliding window symbolic word unit. A short
// directed table and random sample series under several register settings
// are checked symbol by symbol against a behavioral word predictor.
// ----------------------------------------------------------------------------
module tb_sax_sliding_window_words_unit;
    import sswu_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 1500;

    typedef struct {
        logic [CNT_W-1:0]     wstart;
        logic [POS_IDX_W-1:0] pos;
        logic [SYM_W-1:0]     sym;
        logic                 last;
    } t_symbol;

    typedef struct {
        logic signed [15:0] sample;
        bit                 start;
        int                 typed_sym;
    } t_row;

    typedef struct {
        int n_reg;
        int w_reg;
        int a_reg;
        int thr;
        int mode;
        int items;
        bit quiet;
    } t_phase;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_stall;
    logic signed [15:0]     i_sample;
    logic                   i_series_start;
    logic                   o_valid;
    logic                   i_stall;
    logic [CNT_W-1:0]       o_window_start;
    logic [POS_IDX_W-1:0]   o_symbol_position;
    logic [SYM_W-1:0]       o_symbol;
    logic                   o_last;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    sax_sliding_window_words_unit dut (.*);

    // Word predictor state.
    int              cfg_n, cfg_w, cfg_a, cfg_thr, cfg_mode;
    int              ring [MAX_WINDOW];
    int              fill;
    logic [31:0]     series_cnt;
    int              wpos;
    int              prev_word [MAX_WORD];
    int              prev_len;
    bit              prev_valid;

    t_symbol         pending_symbols [$];
    int              errors, items_sent, symbols_seen, words_dropped, idle_cycles;
    bit              quiet_mode;
    bit              finished;

    always begin
        i_clk = 1'b1; #10;
        i_clk = 1'b0; #10;
    end

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic int clamp(int v, int lo, int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    task automatic predict_word(input logic signed [15:0] smp, input bit start,
                                input int typed_sym);
        int      win [MAX_WINDOW];
        int      word [MAX_WORD];
        int      n, w, a, diff, sym;
        longint  s, q, d, sd, p, b;
        bit      flat, drop, ge;
        t_symbol e;
        if (start) begin
            fill = 0;
            series_cnt = 0;
            prev_valid = 0;
        end
        ring[wpos] = smp;
        wpos = (wpos + 1) % MAX_WINDOW;
        if (fill < MAX_WINDOW) fill++;
        if (series_cnt != 32'hFFFF_FFFF) series_cnt++;
        n = clamp(cfg_n, 2, MAX_WINDOW);
        if (fill < n) return;
        w = clamp(cfg_w, 1, MAX_WORD);
        a = clamp(cfg_a, MIN_ALPHA, MAX_ALPHA);
        s = 0;
        q = 0;
        for (int i = 0; i < n; i++) begin
            win[i] = ring[(wpos + MAX_WINDOW - n + i) % MAX_WINDOW];
            s += win[i];
            q += longint'(win[i]) * win[i];
        end
        d = longint'(n) * q - s * s;
        if (d < 0) d = 0;
        sd = longint'(isqrt(longint'(d) / (longint'(n) * (n - 1))));
        flat = (sd == 0) || (sd < cfg_thr);
        for (int j = 0; j < w; j++) begin
            p = 0;
            sym = 0;
            for (int i = j * n; i < (j + 1) * n; i++) p += win[i / w];
            for (int k = 0; k + 1 < a; k++) begin
                b = CUT_TAB[a - 2][k];
                ge = flat ? (100 * p >= b * 256 * n) : (100 * (p - s) >= b * sd * n);
                if (ge) sym++;
            end
            word[j] = sym;
        end
        drop = 0;
        if (prev_valid && prev_len == w && (cfg_mode == 1 || cfg_mode == 2)) begin
            drop = 1;
            for (int j = 0; j < w; j++) begin
                diff = word[j] - prev_word[j];
                if (diff < 0) diff = -diff;
                if (diff > (cfg_mode == 1 ? 0 : 1)) drop = 0;
            end
        end
        if (drop) begin
            words_dropped++;
            return;
        end
        for (int j = 0; j < w; j++) prev_word[j] = word[j];
        prev_len = w;
        prev_valid = 1;
        for (int j = 0; j < w; j++) begin
            e.wstart = (series_cnt == 32'hFFFF_FFFF) ? series_cnt : series_cnt - n;
            e.pos    = POS_IDX_W'(j);
            e.sym    = SYM_W'((typed_sym >= 0) ? typed_sym : word[j]);
            e.last   = (j + 1 == w);
            pending_symbols.insert(pending_symbols.size(), e);
        end
    endtask

    task automatic write_reg(input t_reg_idx idx, input int value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = CFG_DATA_W'(value);
        do @(posedge i_clk); while (!o_cfg_ready);
        idle_cycles = 0;
        case (idx)
            REG_WINDOW_LENGTH:  cfg_n    = value & 'h1FF;
            REG_WORD_LENGTH:    cfg_w    = value & 'h1F;
            REG_ALPHABET_SIZE:  cfg_a    = value & 'h1F;
            REG_FLAT_THRESHOLD: cfg_thr  = value & 'hFFFF;
            REG_REDUCTION_MODE: cfg_mode = value & 'h3;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic send_sample(input logic signed [15:0] smp, input bit start,
                               input int typed_sym);
        while (!quiet_mode && $urandom_range(99) < 7) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid        = 1'b1;
        i_sample       = smp;
        i_series_start = start;
        do @(posedge i_clk); while (o_stall);
        idle_cycles = 0;
        items_sent++;
        predict_word(smp, start, typed_sym);
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic settle();
        while (pending_symbols.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic signed [15:0] make_sample(int style, int idx, int level);
        case (style)
            0: return 16'($urandom);
            1: return 16'(level + $signed($urandom_range(8)) - 4);
            2: return 16'(level);
            default: return 16'(((idx % 8) < 4) ? level + 512 : level - 512);
        endcase
    endfunction

    // Output side: random stall and in-order comparison.
    always @(negedge i_clk) begin
        if (!i_rst_n) i_stall <= 1'b0;
        else i_stall <= !quiet_mode && ($urandom_range(99) < 7);
    end

    always @(posedge i_clk) begin
        t_symbol e;
        if (i_rst_n && o_valid && !i_stall) begin
            idle_cycles = 0;
            symbols_seen++;
            if (pending_symbols.size() == 0) begin
                $display("%0t: unexpected symbol start=%0d pos=%0d sym=%0d last=%0d",
                         $time, o_window_start, o_symbol_position, o_symbol, o_last);
                errors++;
            end else begin
                e = pending_symbols.pop_front();
                if (o_window_start !== e.wstart) begin
                    $display("%0t: window_start expected %0d actual %0d",
                             $time, e.wstart, o_window_start);
                    errors++;
                end
                if (o_symbol_position !== e.pos) begin
                    $display("%0t: symbol_position expected %0d actual %0d",
                             $time, e.pos, o_symbol_position);
                    errors++;
                end
                if (o_symbol !== e.sym) begin
                    $display("%0t: symbol expected %0d actual %0d", $time, e.sym, o_symbol);
                    errors++;
                end
                if (o_last !== e.last) begin
                    $display("%0t: last expected %0d actual %0d", $time, e.last, o_last);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && !finished) begin
            idle_cycles++;
            if (idle_cycles > WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired, %0d symbols outstanding",
                         $time, pending_symbols.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    t_row dir_rows [] = '{
        '{16'sh0000, 1'b1, -1},
        '{16'sh0000, 1'b0, 2},
        '{16'sh7FFF, 1'b0, -1},
        '{-16'sh8000, 1'b0, -1},
        '{-16'sh8000, 1'b0, 0},
        '{-16'sh8000, 1'b0, 0},
        '{16'sh0001, 1'b1, -1},
        '{-16'sh0001, 1'b0, -1},
        '{16'sh0002, 1'b0, -1},
        '{16'sh0100, 1'b0, -1},
        '{-16'sh0100, 1'b0, -1},
        '{16'sh5555, 1'b0, -1},
        '{-16'sh5556, 1'b0, -1},
        '{16'sh7FFF, 1'b0, -1},
        '{16'sh7FFF, 1'b0, 3},
        '{16'sh0000, 1'b1, -1},
        '{16'sh00AA, 1'b0, -1}
    };

    t_phase phases [] = '{
        '{2,   1,  2,  0,     3, 20,  1'b1},
        '{8,   4,  4,  3,     1, 20,  1'b0},
        '{16,  16, 20, 65535, 2, 25,  1'b0},
        '{1,   0,  1,  100,   2, 15,  1'b0},
        '{33,  31, 31, 3,     1, 38,  1'b0},
        '{40,  5,  10, 0,     0, 45,  1'b0},
        '{12,  16, 7,  500,   2, 20,  1'b0},
        '{5,   3,  3,  3,     0, 15,  1'b0}
    };

    initial begin
        int style, level;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_sample = '0;
        i_series_start = 1'b0;
        i_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_WINDOW_LENGTH;
        i_cfg_data = '0;
        cfg_n = 128; cfg_w = 4; cfg_a = 4; cfg_thr = 3; cfg_mode = 1;
        fill = 0; series_cnt = 0; wpos = 0; prev_len = 0; prev_valid = 0;
        errors = 0; items_sent = 0; symbols_seen = 0; words_dropped = 0;
        idle_cycles = 0; quiet_mode = 0; finished = 0;
        foreach (ring[i]) ring[i] = 0;
        foreach (prev_word[i]) prev_word[i] = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        write_reg(REG_WINDOW_LENGTH, 2);
        write_reg(REG_WORD_LENGTH, 2);
        write_reg(REG_ALPHABET_SIZE, 4);
        write_reg(REG_FLAT_THRESHOLD, 3);
        write_reg(REG_REDUCTION_MODE, 0);
        foreach (dir_rows[r]) send_sample(dir_rows[r].sample, dir_rows[r].start,
                                          dir_rows[r].typed_sym);
        settle();

        foreach (phases[ph]) begin
            write_reg(REG_WINDOW_LENGTH, phases[ph].n_reg);
            write_reg(REG_WORD_LENGTH, phases[ph].w_reg);
            write_reg(REG_ALPHABET_SIZE, phases[ph].a_reg);
            write_reg(REG_FLAT_THRESHOLD, phases[ph].thr);
            write_reg(REG_REDUCTION_MODE, phases[ph].mode);
            quiet_mode = phases[ph].quiet;
            style = 0;
            level = $signed(16'($urandom));
            for (int it = 0; it < phases[ph].items; it++) begin
                if (it % 10 == 0) begin
                    style = $urandom_range(3);
                    level = $signed(16'($urandom_range(4096))) - 2048;
                end
                send_sample(make_sample(style, it, level),
                            (it == 0) || ($urandom_range(99) < 2), -1);
            end
            settle();
        end

        finished = 1;
        $display("Sent %0d samples over %0d register settings; %0d symbols checked.",
                 items_sent, phases.size() + 1, symbols_seen);
        $display("Repeat words dropped by the predictor: %0d.", words_dropped);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/sswu_pkg.sv
rtl/sswu_ctrl.sv
rtl/sswu_datapath.sv
rtl/sax_sliding_window_words_unit.sv
tb/tb_sax_sliding_window_words_unit.sv
